// ===== hdl/key_orbit_xor_cipher_unit_assert.svh =====
// assertion macros for the key orbit xor cipher checker
// no dependencies; included by the checker file only
`ifndef KEY_ORBIT_XOR_CIPHER_UNIT_ASSERT_SVH
`define KEY_ORBIT_XOR_CIPHER_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define KOX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define KOX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/kox_pkg.sv =====
// shared types and constants for the key orbit xor cipher
// no dependencies; imported by every module of the block
package kox_pkg;

  localparam int unsigned KEY_DEPTH_DEF = 256;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned KIDX_W        = 8;
  localparam int unsigned KLEN_W        = 9;
  localparam int unsigned CMD_W         = 2;
  localparam logic [KLEN_W-1:0] KLEN_RESET = 9'd2;

  // input command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_KEY_WR = 2'd0,
    CMD_CIPHER = 2'd1,
    CMD_START  = 2'd2
  } cmd_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic key_wr;
    logic start;
    logic cipher_init;
    logic mod_step;
    logic walk_step;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic mod_last;
    logic walk_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/kox_ctrl.sv =====
// controller state machine of the key orbit xor cipher
// depends on kox_pkg for states, command codes and the command/status structs
module kox_ctrl import kox_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] cmd_i,
  input  dp_stat_t         stat_i,
  output ctrl_cmd_t        cmd_o,
  output logic             in_stall_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (cmd_i == CMD_CIPHER)) state_d = ST_MOD;
      end
      ST_MOD: begin
        if (stat_i.mod_last) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (stat_i.walk_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o        = 1'b0;
        cmd_o.key_wr      = in_valid_i && (cmd_i == CMD_KEY_WR);
        cmd_o.start       = in_valid_i && (cmd_i == CMD_START);
        cmd_o.cipher_init = in_valid_i && (cmd_i == CMD_CIPHER);
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o = '0;
      end
      ST_FINISH: begin
        cmd_o.finish = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== hdl/kox_datapath.sv =====
// datapath of the key orbit xor cipher: key store, jump reduction, orbit walk
// and output register; depends on kox_pkg
module kox_datapath import kox_pkg::*; #(
  parameter int unsigned KEY_DEPTH = KEY_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [KLEN_W-1:0] cfg_wdata_i,
  input  logic [KIDX_W-1:0] key_index_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  ctrl_cmd_t         cmd_i,
  output dp_stat_t          stat_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [BYTE_W-1:0] out_byte_o
);

  localparam int unsigned AW  = (KEY_DEPTH > 2) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned NW  = $clog2(KEY_DEPTH + 1);
  localparam int unsigned CW  = (NW > KLEN_W) ? NW : KLEN_W;
  localparam int unsigned KW  = (AW > KIDX_W) ? AW : KIDX_W;
  localparam int unsigned CBW = $clog2(AW + 1);

  logic [KLEN_W-1:0] key_length_q;
  logic              pos_odd_q;
  logic [AW-1:0]     jump_q;
  logic [BYTE_W-1:0] key_mem [KEY_DEPTH];
  logic [BYTE_W-1:0] rd_data_q;
  logic              rd_valid_q;
  logic [BYTE_W-1:0] byte_q;
  logic [NW-1:0]     rem_q;
  logic [AW-1:0]     div_q;
  logic [CBW-1:0]    bit_cnt_q;
  logic [AW-1:0]     idx_q;
  logic [NW-1:0]     steps_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;

  logic [CW-1:0]     klen_ext;
  logic [CW-1:0]     len_ext;
  logic [NW-1:0]     len;
  logic [NW:0]       rem_sh;
  logic [NW-1:0]     rem_d;
  logic [NW:0]       idx_sum;
  logic [AW-1:0]     idx_next;
  logic [AW-1:0]     start_idx;
  logic [NW-1:0]     steps_inc;
  logic [NW-1:0]     rem_inc;
  logic [NW-1:0]     jump_new;
  logic [KW:0]       wr_addr;
  logic              wr_en;
  logic              out_free;

  // effective key length, saturated into two to key depth
  assign klen_ext = CW'(key_length_q);
  always_comb begin
    priority if (klen_ext < CW'(2)) begin
      len_ext = CW'(2);
    end else if (klen_ext > CW'(KEY_DEPTH)) begin
      len_ext = CW'(KEY_DEPTH);
    end else begin
      len_ext = klen_ext;
    end
  end
  assign len = len_ext[NW-1:0];

  // key length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KLEN_RESET;
    end else if (cfg_we_i) begin
      key_length_q <= cfg_wdata_i;
    end
  end

  // key store, one write and one registered read per cycle
  assign wr_addr = (KW+1)'(key_index_i);
  assign wr_en   = cmd_i.key_wr && (wr_addr < (KW+1)'(KEY_DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr[AW-1:0]] <= data_byte_i;
    end
    rd_data_q <= key_mem[idx_q];
  end

  // restoring remainder step: jump modulo effective length, one bit a cycle
  assign rem_sh = {rem_q, div_q[AW-1]};
  always_comb begin
    if (rem_sh >= (NW+1)'(len)) begin
      rem_d = NW'(rem_sh - (NW+1)'(len));
    end else begin
      rem_d = rem_sh[NW-1:0];
    end
  end

  // orbit step: index plus jump, wrapped once
  assign idx_sum = (NW+1)'(idx_q) + (NW+1)'(rem_q);
  always_comb begin
    if (idx_sum >= (NW+1)'(len)) begin
      idx_next = AW'(idx_sum - (NW+1)'(len));
    end else begin
      idx_next = idx_sum[AW-1:0];
    end
  end
  assign start_idx = AW'(pos_odd_q);
  assign steps_inc = steps_q + NW'(1);

  // jump for the next byte, grown after an odd position
  assign rem_inc = rem_q + NW'(1);
  always_comb begin
    if (pos_odd_q) begin
      jump_new = (rem_inc == len) ? '0 : rem_inc;
    end else begin
      jump_new = rem_q;
    end
  end

  // message framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_odd_q <= 1'b0;
      jump_q    <= '0;
    end else if (cmd_i.start) begin
      pos_odd_q <= 1'b0;
      jump_q    <= (len == NW'(2)) ? '0 : AW'(2);
    end else if (cmd_i.finish) begin
      pos_odd_q <= ~pos_odd_q;
      jump_q    <= jump_new[AW-1:0];
    end
  end

  // reduction and walk counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.walk_step;
      if (cmd_i.cipher_init) begin
        bit_cnt_q <= '0;
      end else if (cmd_i.mod_step) begin
        bit_cnt_q <= bit_cnt_q + CBW'(1);
      end
    end
  end

  // reduction and walk operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.cipher_init) begin
      rem_q   <= '0;
      div_q   <= jump_q;
      idx_q   <= start_idx;
      steps_q <= '0;
    end else if (cmd_i.mod_step) begin
      rem_q <= rem_d;
      div_q <= div_q << 1;
    end else if (cmd_i.walk_step) begin
      idx_q   <= idx_next;
      steps_q <= steps_inc;
    end
  end

  // byte accumulator, xor of each key byte as its read returns
  always_ff @(posedge clk_i) begin
    if (cmd_i.cipher_init) begin
      byte_q <= data_byte_i;
    end else if (rd_valid_q) begin
      byte_q <= byte_q ^ rd_data_q;
    end
  end

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_byte_q <= byte_q;
    end
  end

  // status to the controller
  assign stat_o.mod_last  = (bit_cnt_q == CBW'(AW - 1));
  assign stat_o.walk_last = (idx_next == start_idx) || (steps_inc == len);
  assign stat_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule

// ===== hdl/key_orbit_xor_cipher_unit.sv =====
// top level of the key orbit xor cipher
// depends on kox_pkg, kox_ctrl and kox_datapath
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------
//   input    | in_valid_i / in_stall_o | cmd_i, key_index_i, data_byte_i
//   output   | out_valid_o/out_stall_i | out_byte_o
//   config   | cfg_we_i                | cfg_wdata_i (key length)
//
// key write and start transactions never stall the input
// a cipher transaction reduces the jump over its AW bits (AW = key store
// address width), then makes L key store reads (L = orbit length, at most the
// effective key length) at one read a cycle through the single key store port
// the key store has no reset; it must be written before use
// a finished byte sits in the output register, so a stalled output only
// holds the block once a second result is ready
module key_orbit_xor_cipher_unit import kox_pkg::*; #(
  parameter int unsigned KEY_DEPTH = KEY_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [KLEN_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [KIDX_W-1:0] key_index_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] out_byte_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // controller
  kox_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd),
    .in_stall_o (in_stall_o)
  );

  // datapath
  kox_datapath #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_index_i (key_index_i),
    .data_byte_i (data_byte_i),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o)
  );

endmodule

// ===== hdl/kox_checker.sv =====
// port level checker for the key orbit xor cipher, bound to the top level
// depends on kox_pkg and key_orbit_xor_cipher_unit_assert.svh
`include "key_orbit_xor_cipher_unit_assert.svh"

module kox_checker import kox_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic [KLEN_W-1:0] cfg_wdata_i,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [CMD_W-1:0]  cmd_i,
  input logic [KIDX_W-1:0] key_index_i,
  input logic [BYTE_W-1:0] data_byte_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [BYTE_W-1:0] out_byte_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result holds its value
  `KOX_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o), "result changed while stalled")

  // a cipher transaction keeps the input side busy afterwards
  `KOX_ASSERT_NEXT(a_cipher_busy, in_acc && (cmd_i == CMD_CIPHER), in_stall_o, "input taken during a cipher walk")

  // key writes, starts and unused codes leave the input free in the next cycle
  `KOX_ASSERT_NEXT(a_short_free, in_acc && (cmd_i != CMD_CIPHER), !in_stall_o, "short transaction kept the input stalled")

  // a new result only appears at the end of a busy period
  `KOX_ASSERT_NOW(a_out_from_walk, $rose(out_valid_o), $past(in_stall_o), "result appeared without a cipher walk")

endmodule

bind key_orbit_xor_cipher_unit kox_checker u_kox_checker (.*);

// ===== tb/sv/key_orbit_xor_cipher_unit_test.sv =====
// self-checking testbench for key_orbit_xor_cipher_unit
// depends on kox_pkg and the block's rtl; predicts every ciphered byte and
// checks it against the output channel under random idling on both sides
`timescale 1ns / 1ps

module key_orbit_xor_cipher_unit_test;
  import kox_pkg::*;

  localparam int unsigned      KEY_ENTRIES   = KEY_DEPTH_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED    = 2'd3;
  localparam int unsigned      JUMP_INIT     = 2;
  localparam int unsigned      MIN_KEY_LEN   = 2;
  localparam int unsigned      MAX_GAP       = 11;
  localparam int unsigned      MAX_REPORTS   = 10;
  // key writes, starts and unused commands never keep the input stalled
  localparam int unsigned      IDLE_PAD      = 8;
  // one cipher transaction at full key length plus margin
  localparam int unsigned      DRAIN_PAD     = 300;
  localparam int unsigned      RANDOM_PHASES = 10;
  localparam int unsigned      PHASE_ITEMS   = 40;
  localparam int unsigned      TIMEOUT_NS    = 6_000_000;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [KLEN_W-1:0] cfg_wdata = KLEN_RESET;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  cmd       = CMD_START;
  logic [KIDX_W-1:0] key_index = '0;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte;

  // predictor state
  logic [BYTE_W-1:0] key_mem [KEY_ENTRIES];
  logic [KLEN_W-1:0] key_len_reg;
  bit                odd_pos;
  int unsigned       jump_reg;
  logic [BYTE_W-1:0] expected_bytes [$];

  // run control and bookkeeping
  bit          src_gaps_on    = 1'b1;
  bit          sink_stalls_on = 1'b1;
  int unsigned hold_left      = 0;
  int unsigned errors         = 0;
  int unsigned items_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes     = 0;

  key_orbit_xor_cipher_unit #(
    .KEY_DEPTH(KEY_ENTRIES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .cmd_i      (cmd),
    .key_index_i(key_index),
    .data_byte_i(data_byte),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_byte_o (out_byte)
  );

  always #1 clk_i = ~clk_i;

  // key length as the block uses it, saturated into the legal range
  function automatic int unsigned effective_key_len();
    int unsigned n;
    n = key_len_reg;
    if (n < MIN_KEY_LEN) n = MIN_KEY_LEN;
    if (n > KEY_ENTRIES) n = KEY_ENTRIES;
    return n;
  endfunction

  // walk the key orbit from the position parity and xor every key byte met
  function automatic logic [BYTE_W-1:0] predict_orbit_xor(input logic [BYTE_W-1:0] msg);
    int unsigned       n;
    int unsigned       stride;
    int unsigned       origin;
    int unsigned       idx;
    int unsigned       walked;
    logic [BYTE_W-1:0] acc;
    n      = effective_key_len();
    stride = jump_reg % n;
    origin = odd_pos;
    idx    = origin;
    walked = 0;
    acc    = msg;
    do begin
      acc    = acc ^ key_mem[idx];
      idx    = (idx + stride) % n;
      walked++;
    end while (idx != origin && walked < n);
    // the jump grows after every odd-position byte
    if (odd_pos) stride = (stride + 1) % n;
    jump_reg = stride;
    odd_pos  = ~odd_pos;
    return acc;
  endfunction

  // update the predictor for one accepted transaction
  function automatic void apply_to_model(input logic [CMD_W-1:0] op,
                                         input logic [KIDX_W-1:0] addr,
                                         input logic [BYTE_W-1:0] value);
    case (op)
      CMD_KEY_WR: begin
        key_mem[addr] = value;
      end
      CMD_CIPHER: begin
        expected_bytes.push_back(predict_orbit_xor(value));
      end
      CMD_START: begin
        odd_pos  = 1'b0;
        jump_reg = JUMP_INIT % effective_key_len();
      end
      default: begin
        // unused command: no effect, no result
      end
    endcase
  endfunction

  // compare one accepted output transaction with the oldest prediction
  function automatic void check_result(input logic [BYTE_W-1:0] got);
    logic [BYTE_W-1:0] want;
    if (expected_bytes.size() == 0) begin
      if (errors < MAX_REPORTS)
        $display("ERROR: unexpected output byte %02h at %0t", got, $time);
      errors++;
    end else begin
      want = expected_bytes.pop_front();
      results_checked++;
      if (got !== want) begin
        if (errors < MAX_REPORTS)
          $display("ERROR: out_byte expected %02h actual %02h at %0t", want, got, $time);
        errors++;
      end
    end
  endfunction

  // output side: check each transaction, then stall for a random while
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_byte);
        hold_left = sink_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0);
    end
  end

  // drive one input transaction after a random gap and wait for acceptance
  task automatic send_item(input logic [CMD_W-1:0] op, input logic [KIDX_W-1:0] addr,
                           input logic [BYTE_W-1:0] value);
    int unsigned gap;
    gap = src_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    key_index <= addr;
    data_byte <= value;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    apply_to_model(op, addr, value);
    items_sent++;
  endtask

  // random filler for fields the command ignores
  task automatic send_cipher(input logic [BYTE_W-1:0] value);
    send_item(CMD_CIPHER, KIDX_W'($urandom_range(0, 255)), value);
  endtask

  task automatic send_start();
    send_item(CMD_START, KIDX_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
  endtask

  // stop sending and let every outstanding transaction complete
  task automatic wait_block_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (IDLE_PAD) @(posedge clk_i);
  endtask

  task automatic write_key_length(input logic [KLEN_W-1:0] value);
    wait_block_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    key_len_reg = value;
    cfg_writes++;
  endtask

  // every key entry gets a byte, so no read ever hits an unwritten entry
  task automatic test_key_load();
    int unsigned i;
    for (i = 0; i < KEY_ENTRIES; i++)
      send_item(CMD_KEY_WR, KIDX_W'(i), BYTE_W'($urandom_range(0, 255)));
  endtask

  // reset key length of two with a zero jump
  task automatic test_reset_key_length();
    send_cipher(8'h00);
    send_cipher(8'hFF);
    send_cipher(8'h5A);
    send_cipher(8'hA5);
  endtask

  // lengths below two and above the store depth saturate
  task automatic test_length_saturation();
    logic [KLEN_W-1:0] lens [5];
    int unsigned       i;
    lens = '{9'd0, 9'd1, 9'd511, 9'd257, 9'd256};
    for (i = 0; i < 5; i++) begin
      write_key_length(lens[i]);
      send_cipher(8'hFF);
      send_cipher(8'h00);
    end
  endtask

  task automatic test_unused_cmd();
    send_item(CMD_UNUSED, 8'hFF, 8'hFF);
    send_item(CMD_UNUSED, 8'h00, 8'h00);
  endtask

  // overwrite the end entries of the store and use them at full length
  task automatic test_key_overwrite();
    send_item(CMD_KEY_WR, 8'hFF, 8'h00);
    send_item(CMD_KEY_WR, 8'h00, 8'hFF);
    send_cipher(8'h00);
  endtask

  // the stored jump carries over a key length change with no start
  task automatic test_midmessage_length_change();
    write_key_length(9'd5);
    send_start();
    send_cipher(8'h3C);
    send_cipher(8'hC3);
    write_key_length(9'd7);
    send_cipher(8'h96);
    send_cipher(8'h69);
  endtask

  // start resets position and jump in the middle of a message
  task automatic test_start_cmd();
    send_cipher(8'h11);
    send_start();
    send_cipher(8'h22);
  endtask

  // phases of random key length; mostly messages framed by a start
  task automatic test_random_traffic();
    int unsigned       phase;
    int unsigned       n;
    int unsigned       pick;
    logic [KLEN_W-1:0] len;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) len = KLEN_W'($urandom_range(2, 16));
      else if (pick < 9) len = KLEN_W'($urandom_range(17, 256));
      else len = KLEN_W'($urandom_range(0, 511));
      write_key_length(len);
      src_gaps_on    = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) send_start();
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 72)
          send_cipher(BYTE_W'($urandom_range(0, 255)));
        else if (pick < 80)
          send_start();
        else if (pick < 93)
          send_item(CMD_KEY_WR, KIDX_W'($urandom_range(0, 255)),
                    BYTE_W'($urandom_range(0, 255)));
        else
          send_item(CMD_UNUSED, KIDX_W'($urandom_range(0, 255)),
                    BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    key_len_reg = KLEN_RESET;
    odd_pos     = 1'b0;
    jump_reg    = JUMP_INIT % effective_key_len();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_key_load();
    test_reset_key_length();
    test_length_saturation();
    test_unused_cmd();
    test_key_overwrite();
    test_midmessage_length_change();
    test_start_cmd();
    test_random_traffic();

    wait_block_idle();
    repeat (DRAIN_PAD) @(posedge clk_i);
    if (expected_bytes.size() != 0) begin
      $display("ERROR: %0d expected bytes never arrived", expected_bytes.size());
      errors++;
    end

    $display("summary: %0d input transactions, %0d ciphered bytes checked, %0d key length writes",
             items_sent, results_checked, cfg_writes);
    $display("summary: %0d mismatches or unexpected outputs", errors);
    if (errors == 0) begin
      $display("key_orbit_xor_cipher_unit test passed");
    end else begin
      $display("key_orbit_xor_cipher_unit test failed");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #TIMEOUT_NS;
    $display("ERROR: timeout with %0d bytes outstanding", expected_bytes.size());
    $display("key_orbit_xor_cipher_unit test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/kox_pkg.sv
hdl/kox_ctrl.sv
hdl/kox_datapath.sv
hdl/key_orbit_xor_cipher_unit.sv
hdl/kox_checker.sv
tb/sv/key_orbit_xor_cipher_unit_test.sv
